// ===== design/assert_macros.svh =====
// Assertion helpers shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, ignored while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/pbpr_pkg.sv =====
`default_nettype none
package pbpr_pkg;

  localparam logic [2:0] KIND_PIN    = 3'd0;
  localparam logic [2:0] KIND_UNPIN  = 3'd1;
  localparam logic [2:0] KIND_DIRTY  = 3'd2;
  localparam logic [2:0] KIND_FORCE  = 3'd3;
  localparam logic [2:0] KIND_FLUSH  = 3'd4;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND  = 2'd1;
  localparam logic [1:0] STATUS_ALL_PINNED = 2'd2;

  localparam logic CFG_STRATEGY      = 1'b0;
  localparam logic CFG_FRAMES_IN_USE = 1'b1;

  localparam int         PIN_BITS    = 16;
  localparam int         STAMP_BITS  = 32;
  localparam logic [4:0] RESULT_CAP  = 5'd16;

  typedef struct packed {
    logic [2:0]  kind;
    logic [19:0] page_number;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [3:0]  frame_index;
    logic        write_back;
    logic [19:0] write_page;
    logic        read_in;
    logic [19:0] read_page;
    logic        last;
    logic [31:0] read_io_count;
    logic [31:0] write_io_count;
  } out_t;

  typedef struct packed {
    logic accept;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_done;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== design/pbpr_ctrl.sv =====
`default_nettype none
module pbpr_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  output pbpr_pkg::ctl_cmd_t cmd,
  input  pbpr_pkg::dp_sts_t  sts
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (start) state_nxt = S_SCAN;
      S_SCAN:   if (sts.scan_done) state_nxt = S_COMMIT;
      S_COMMIT: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign cmd.accept = (state_r == S_IDLE) && start;
  assign cmd.commit = (state_r == S_COMMIT);

`include "assert_macros.svh"
  `ASSERT_CLK(a_commit_idle, state_r == S_COMMIT |=> state_r == S_IDLE, "commit did not end")
  `ASSERT_CLK(a_done_in_scan, sts.scan_done |-> state_r == S_SCAN, "scan end outside scan")

endmodule
`default_nettype wire

// ===== design/pbpr_dp.sv =====
`default_nettype none
module pbpr_dp #(
  parameter int NUM_FRAMES       = 16,
  parameter int PAGE_NUMBER_BITS = 20
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire                cfg_index,
  input  wire  [4:0]         cfg_wdata,
  input  pbpr_pkg::in_t      in_data,
  input  pbpr_pkg::ctl_cmd_t cmd,
  output pbpr_pkg::dp_sts_t  sts,
  output logic               out_valid,
  output pbpr_pkg::out_t     out_data
);

  localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int PW = (PAGE_NUMBER_BITS > 20) ? PAGE_NUMBER_BITS : 20;
  localparam int SB = pbpr_pkg::STAMP_BITS;
  localparam int PN = pbpr_pkg::PIN_BITS;

  typedef struct packed {
    logic [PAGE_NUMBER_BITS-1:0] page;
    logic [PN-1:0]               pins;
    logic                        dirty;
    logic [SB-1:0]               ld;
    logic [SB-1:0]               us;
  } ent_t;

  function automatic logic [19:0] pg20(input logic [PAGE_NUMBER_BITS-1:0] p);
    logic [PW-1:0] t;
    t = PW'(p);
    return t[19:0];
  endfunction

  // frame table
  ent_t mem [NUM_FRAMES];
  ent_t rdata_r;
  logic mem_we;
  logic [IW-1:0] mem_wa;
  ent_t mem_wd;

  logic            strategy_r;
  logic [4:0]      fiu_r;
  logic [NUM_FRAMES-1:0] valid_r;
  logic [SB-1:0]   load_r, use_r, reads_r, writes_r;

  logic [2:0]                  kind_r;
  logic [PAGE_NUMBER_BITS-1:0] req_page_r;
  logic [PW-1:0]               pg_in;

  logic            issuing_r, rd_vld_r, rd_valid_r;
  logic [IW-1:0]   addr_r, rd_idx_r, n_last;
  logic [6:0]      act;

  logic            found_r;
  logic [IW-1:0]   f_idx_r;
  ent_t            f_ent_r;
  logic            vic_found_r, vic_valid_r, vic_dirty_r;
  logic [IW-1:0]   vic_idx_r;
  logic [SB-1:0]   vic_best_r;
  logic [PAGE_NUMBER_BITS-1:0] vic_page_r;
  logic [4:0]      fl_cnt_r;

  pbpr_pkg::out_t  pend_r, pend_nxt, res;
  logic            pend_vld_r, pend_v_nxt, out_v_nxt;

  ent_t            ev;
  logic [SB-1:0]   stamp;
  logic            is_match, is_cand, flush_hit;
  logic            set_vld, rd_inc, wr_inc, ld_inc;
  logic [1:0]      us_add;

  assign pg_in = PW'(in_data.page_number);
  assign act   = (fiu_r == 5'd0) ? 7'd1 :
                 ((7'(fiu_r) > 7'(NUM_FRAMES)) ? 7'(NUM_FRAMES) : 7'(fiu_r));
  assign n_last = IW'(act - 7'd1);
  assign sts.scan_done = rd_vld_r && (rd_idx_r == n_last);

  always_comb begin
    ev = rdata_r;
    if (!rd_valid_r) begin
      ev.pins  = '0;
      ev.dirty = 1'b0;
      ev.ld    = SB'(rd_idx_r);
      ev.us    = SB'(rd_idx_r);
    end
    stamp     = strategy_r ? ev.us : ev.ld;
    is_match  = rd_valid_r && (ev.page == req_page_r) && (kind_r <= pbpr_pkg::KIND_FORCE);
    is_cand   = (ev.pins == '0) && (!vic_found_r || (stamp < vic_best_r));
    flush_hit = (kind_r == pbpr_pkg::KIND_FLUSH) && rd_valid_r && ev.dirty &&
                (ev.pins == '0) && (fl_cnt_r < pbpr_pkg::RESULT_CAP);
  end

  always_comb begin
    mem_we     = 1'b0;
    mem_wa     = rd_idx_r;
    mem_wd     = ev;
    set_vld    = 1'b0;
    rd_inc     = 1'b0;
    wr_inc     = 1'b0;
    ld_inc     = 1'b0;
    us_add     = 2'd0;
    out_v_nxt  = 1'b0;
    res        = '0;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_vld_r;
    if (rd_vld_r && flush_hit) begin
      mem_we       = 1'b1;
      mem_wd.dirty = 1'b0;
      wr_inc       = 1'b1;
      if (pend_vld_r) begin
        out_v_nxt = 1'b1;
        res       = pend_r;
      end
      pend_v_nxt              = 1'b1;
      pend_nxt                = '0;
      pend_nxt.status         = pbpr_pkg::STATUS_OK;
      pend_nxt.frame_index    = 4'(rd_idx_r);
      pend_nxt.write_back     = 1'b1;
      pend_nxt.write_page     = pg20(ev.page);
      pend_nxt.read_io_count  = reads_r;
      pend_nxt.write_io_count = writes_r + 32'd1;
    end
    if (cmd.commit) begin
      res.last = 1'b1;
      unique case (kind_r)
        pbpr_pkg::KIND_PIN: begin
          out_v_nxt = 1'b1;
          if (found_r) begin
            mem_we      = 1'b1;
            mem_wa      = f_idx_r;
            mem_wd      = f_ent_r;
            if (f_ent_r.pins != {PN{1'b1}}) mem_wd.pins = f_ent_r.pins + 1'b1;
            mem_wd.us   = use_r;
            us_add      = 2'd1;
            res.hit     = 1'b1;
            res.frame_index = 4'(f_idx_r);
          end else if (!vic_found_r) begin
            res.status = pbpr_pkg::STATUS_ALL_PINNED;
          end else begin
            mem_we       = 1'b1;
            mem_wa       = vic_idx_r;
            mem_wd.page  = req_page_r;
            mem_wd.pins  = PN'(1);
            mem_wd.dirty = 1'b0;
            mem_wd.ld    = load_r;
            mem_wd.us    = use_r + 32'd1;
            set_vld      = 1'b1;
            ld_inc       = 1'b1;
            us_add       = 2'd2;
            rd_inc       = 1'b1;
            wr_inc       = vic_valid_r && vic_dirty_r;
            res.frame_index = 4'(vic_idx_r);
            res.write_back  = vic_valid_r && vic_dirty_r;
            res.write_page  = (vic_valid_r && vic_dirty_r) ? pg20(vic_page_r) : 20'd0;
            res.read_in     = 1'b1;
            res.read_page   = pg20(req_page_r);
          end
        end
        pbpr_pkg::KIND_UNPIN: begin
          out_v_nxt = 1'b1;
          if (found_r) begin
            res.frame_index = 4'(f_idx_r);
            if (f_ent_r.pins != '0) begin
              mem_we      = 1'b1;
              mem_wa      = f_idx_r;
              mem_wd      = f_ent_r;
              mem_wd.pins = f_ent_r.pins - 1'b1;
            end
          end
        end
        pbpr_pkg::KIND_DIRTY: begin
          out_v_nxt = 1'b1;
          if (found_r) begin
            mem_we          = 1'b1;
            mem_wa          = f_idx_r;
            mem_wd          = f_ent_r;
            mem_wd.dirty    = 1'b1;
            res.frame_index = 4'(f_idx_r);
          end else begin
            res.status = pbpr_pkg::STATUS_NOT_FOUND;
          end
        end
        pbpr_pkg::KIND_FORCE: begin
          out_v_nxt = 1'b1;
          if (found_r) begin
            res.frame_index = 4'(f_idx_r);
            if (f_ent_r.dirty) begin
              mem_we         = 1'b1;
              mem_wa         = f_idx_r;
              mem_wd         = f_ent_r;
              mem_wd.dirty   = 1'b0;
              wr_inc         = 1'b1;
              res.write_back = 1'b1;
              res.write_page = pg20(f_ent_r.page);
            end
          end
        end
        pbpr_pkg::KIND_FLUSH: begin
          if (pend_vld_r) begin
            out_v_nxt  = 1'b1;
            res        = pend_r;
            res.last   = 1'b1;
            pend_v_nxt = 1'b0;
          end
        end
        default: ;
      endcase
      if (kind_r != pbpr_pkg::KIND_FLUSH) begin
        res.read_io_count  = reads_r + 32'(rd_inc);
        res.write_io_count = writes_r + 32'(wr_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (issuing_r) rdata_r <= mem[addr_r];
  end

  // scan pipeline, per-request scan flags, configuration and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strategy_r  <= 1'b0;
      fiu_r       <= 5'd16;
      valid_r     <= '0;
      load_r      <= SB'(NUM_FRAMES);
      use_r       <= SB'(NUM_FRAMES);
      reads_r     <= '0;
      writes_r    <= '0;
      issuing_r   <= 1'b0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      vic_found_r <= 1'b0;
      fl_cnt_r    <= '0;
      pend_vld_r  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == pbpr_pkg::CFG_STRATEGY) strategy_r <= cfg_wdata[0];
        else fiu_r <= cfg_wdata;
      end
      if (set_vld) valid_r[mem_wa] <= 1'b1;
      if (ld_inc) load_r <= load_r + 32'd1;
      use_r    <= use_r + 32'(us_add);
      reads_r  <= reads_r + 32'(rd_inc);
      writes_r <= writes_r + 32'(wr_inc);
      rd_vld_r <= issuing_r;
      out_valid  <= out_v_nxt;
      pend_vld_r <= pend_v_nxt;
      if (cmd.accept) begin
        addr_r      <= '0;
        issuing_r   <= 1'b1;
        found_r     <= 1'b0;
        vic_found_r <= 1'b0;
        fl_cnt_r    <= '0;
      end else if (issuing_r) begin
        if (addr_r == n_last) issuing_r <= 1'b0;
        else addr_r <= addr_r + 1'b1;
      end
      if (rd_vld_r) begin
        if (is_match && !found_r) found_r <= 1'b1;
        if (is_cand) vic_found_r <= 1'b1;
        if (flush_hit) fl_cnt_r <= fl_cnt_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r     <= in_data.kind;
      req_page_r <= pg_in[PAGE_NUMBER_BITS-1:0];
    end
    rd_idx_r   <= addr_r;
    rd_valid_r <= valid_r[addr_r];
    if (rd_vld_r && is_match && !found_r) begin
      f_idx_r <= rd_idx_r;
      f_ent_r <= ev;
    end
    if (rd_vld_r && is_cand) begin
      vic_idx_r   <= rd_idx_r;
      vic_best_r  <= stamp;
      vic_valid_r <= rd_valid_r;
      vic_dirty_r <= ev.dirty;
      vic_page_r  <= ev.page;
    end
    pend_r   <= pend_nxt;
    out_data <= res;
  end

`include "assert_macros.svh"
  `ASSERT_CLK(a_accept_drained, cmd.accept |-> !issuing_r && !rd_vld_r && !pend_vld_r,
              "request taken while scan active")
  `ASSERT_CLK(a_done_issued, sts.scan_done |-> !issuing_r, "scan ended with reads pending")
  `ASSERT_ALWAYS(a_no_out_reset, !rst_n |=> !out_valid, "result right after reset")

endmodule
`default_nettype wire

// ===== design/page_buffer_pool_replacement.sv =====
// Channel   Ports                                 Transfer
// input     start, busy, in_data (in_t)           start && !busy
// result    out_valid, out_data (out_t)           out_valid, one cycle each
// config    cfg_we, cfg_index, cfg_wdata          cfg_we, no wait
//
// A request holds busy while it scans the active frames, n being the active frame
// count: one frame-table read per cycle over the active frames, the registered read,
// one commit. The result strobes in the cycle busy drops, so the next request can be
// taken in that cycle; flush-all results also strobe during the scan, one per cycle
// at most. Reset is synchronous; frame contents are qualified by valid bits, so no
// clearing pass. Results cannot be stalled.
`default_nettype none
module page_buffer_pool_replacement #(
  parameter int NUM_FRAMES       = 16,
  parameter int PAGE_NUMBER_BITS = 20
) (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            start,
  output logic           busy,
  input  pbpr_pkg::in_t  in_data,
  output logic           out_valid,
  output pbpr_pkg::out_t out_data,
  input  wire            cfg_we,
  input  wire            cfg_index,
  input  wire  [4:0]     cfg_wdata
);

  pbpr_pkg::ctl_cmd_t cmd;
  pbpr_pkg::dp_sts_t  sts;

  pbpr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  pbpr_dp #(
    .NUM_FRAMES       (NUM_FRAMES),
    .PAGE_NUMBER_BITS (PAGE_NUMBER_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== tb/page_buffer_pool_replacement_checker.sv =====
`default_nettype none
module page_buffer_pool_replacement_checker (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            start,
  input  wire            busy,
  input  pbpr_pkg::in_t  in_data,
  input  wire            out_valid,
  input  pbpr_pkg::out_t out_data,
  input  wire            cfg_we,
  input  wire            cfg_index,
  input  wire  [4:0]     cfg_wdata,
  output int             fail_count,
  output int             pending,
  output int             results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NF = 16;

  logic        lru_mode;
  logic [4:0]  active_cfg;
  logic [19:0] f_page [NF];
  logic        f_valid [NF];
  logic [15:0] f_pins [NF];
  logic        f_dirty [NF];
  logic [31:0] f_load [NF];
  logic [31:0] f_use [NF];
  logic [31:0] load_ctr, use_ctr, reads_total, writes_total;

  pbpr_pkg::out_t expected_q [$];

  assign pending = expected_q.size();

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  function automatic pbpr_pkg::out_t blank();
    pbpr_pkg::out_t r;
    r = '0;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic push_result(input pbpr_pkg::out_t r);
    r.read_io_count = reads_total;
    r.write_io_count = writes_total;
    expected_q.push_back(r);
  endtask

  task automatic predict_request(input pbpr_pkg::in_t req);
    int n, hit_idx, victim, k;
    logic [31:0] best, s;
    pbpr_pkg::out_t r;
    n = (active_cfg < 1) ? 1 : (active_cfg > NF) ? NF : active_cfg;
    hit_idx = -1;
    victim = -1;
    best = '0;
    k = 0;
    r = blank();
    for (int i = 0; i < n; i++)
      if (hit_idx < 0 && f_valid[i] && f_page[i] == req.page_number) hit_idx = i;
    case (req.kind)
      pbpr_pkg::KIND_PIN: begin
        if (hit_idx >= 0) begin
          if (f_pins[hit_idx] != 16'hFFFF) f_pins[hit_idx]++;
          f_use[hit_idx] = use_ctr;
          use_ctr++;
          r.hit = 1'b1;
          r.frame_index = 4'(hit_idx);
          push_result(r);
        end else begin
          for (int i = 0; i < n; i++) begin
            s = lru_mode ? f_use[i] : f_load[i];
            if (f_pins[i] == 0 && (victim < 0 || s < best)) begin
              victim = i;
              best = s;
            end
          end
          if (victim < 0) begin
            r.status = pbpr_pkg::STATUS_ALL_PINNED;
            push_result(r);
          end else begin
            if (f_valid[victim] && f_dirty[victim]) begin
              r.write_back = 1'b1;
              r.write_page = f_page[victim];
              writes_total++;
            end
            f_load[victim] = load_ctr;
            load_ctr++;
            f_use[victim] = use_ctr + 32'd1;
            use_ctr += 32'd2;
            f_page[victim] = req.page_number;
            f_valid[victim] = 1'b1;
            f_pins[victim] = 16'd1;
            f_dirty[victim] = 1'b0;
            reads_total++;
            r.frame_index = 4'(victim);
            r.read_in = 1'b1;
            r.read_page = req.page_number;
            push_result(r);
          end
        end
      end
      pbpr_pkg::KIND_UNPIN: begin
        if (hit_idx >= 0) begin
          if (f_pins[hit_idx] != 0) f_pins[hit_idx]--;
          r.frame_index = 4'(hit_idx);
        end
        push_result(r);
      end
      pbpr_pkg::KIND_DIRTY: begin
        if (hit_idx < 0) r.status = pbpr_pkg::STATUS_NOT_FOUND;
        else begin
          f_dirty[hit_idx] = 1'b1;
          r.frame_index = 4'(hit_idx);
        end
        push_result(r);
      end
      pbpr_pkg::KIND_FORCE: begin
        if (hit_idx >= 0) r.frame_index = 4'(hit_idx);
        if (hit_idx >= 0 && f_dirty[hit_idx]) begin
          f_dirty[hit_idx] = 1'b0;
          writes_total++;
          r.write_back = 1'b1;
          r.write_page = f_page[hit_idx];
        end
        push_result(r);
      end
      pbpr_pkg::KIND_FLUSH: begin
        for (int i = 0; i < n && k < pbpr_pkg::RESULT_CAP; i++) begin
          if (f_valid[i] && f_dirty[i] && f_pins[i] == 0) begin
            f_dirty[i] = 1'b0;
            writes_total++;
            r = '0;
            r.frame_index = 4'(i);
            r.write_back = 1'b1;
            r.write_page = f_page[i];
            push_result(r);
            k++;
          end
        end
        if (k > 0) expected_q[$].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    pbpr_pkg::out_t exp_r;
    if (!rst_n) begin
      lru_mode <= 1'b0;
      active_cfg <= 5'd16;
      for (int i = 0; i < NF; i++) begin
        f_valid[i] = 1'b0;
        f_page[i] = '0;
        f_pins[i] = '0;
        f_dirty[i] = 1'b0;
        f_load[i] = i;
        f_use[i] = i;
      end
      load_ctr = NF;
      use_ctr = NF;
      reads_total = '0;
      writes_total = '0;
      expected_q.delete();
    end else begin
      // a result can leave in the cycle the next request is taken, so check first
      if (out_valid) begin
        results_seen++;
        if (expected_q.size() == 0) report("result with nothing expected");
        else begin
          exp_r = expected_q.pop_front();
          if (out_data.status !== exp_r.status) report("status");
          if (out_data.hit !== exp_r.hit) report("hit");
          if (out_data.frame_index !== exp_r.frame_index) report("frame_index");
          if (out_data.write_back !== exp_r.write_back) report("write_back");
          if (out_data.write_page !== exp_r.write_page) report("write_page");
          if (out_data.read_in !== exp_r.read_in) report("read_in");
          if (out_data.read_page !== exp_r.read_page) report("read_page");
          if (out_data.last !== exp_r.last) report("last");
          if (out_data.read_io_count !== exp_r.read_io_count) report("read_io_count");
          if (out_data.write_io_count !== exp_r.write_io_count) report("write_io_count");
        end
      end
      if (cfg_we) begin
        if (cfg_index == pbpr_pkg::CFG_STRATEGY) lru_mode <= cfg_wdata[0];
        else active_cfg <= cfg_wdata;
      end
      if (start && !busy) predict_request(in_data);
    end
  end

  initial begin
    fail_count = 0;
    results_seen = 0;
  end
endmodule
`default_nettype wire

// ===== tb/page_buffer_pool_replacement_tb.sv =====
`default_nettype none
module page_buffer_pool_replacement_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           start = 1'b0;
  logic           busy;
  pbpr_pkg::in_t  in_data = '0;
  logic           out_valid;
  pbpr_pkg::out_t out_data;
  logic           cfg_we = 1'b0;
  logic           cfg_index = 1'b0;
  logic [4:0]     cfg_wdata = '0;
  int             fail_count, pending, results_seen;
  int             requests_sent = 0;
  logic [19:0]    hot_pages [8];

  page_buffer_pool_replacement u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  page_buffer_pool_replacement_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // the block is busy right after a transaction, so the trailing edge costs nothing
  task automatic send_request(input logic [2:0] kind, input logic [19:0] page);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(posedge clk);
    start <= 1'b1;
    in_data <= '{kind: kind, page_number: page};
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    requests_sent++;
    @(posedge clk);
  endtask

  // wait for every expected result and for busy to drop, then pad past a full scan
  task automatic wait_idle();
    while (pending != 0 || busy) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [4:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [19:0] pick_page();
    case ($urandom_range(0, 9))
      0: return 20'($urandom());
      1: return 20'hFFFFF;
      default: return hot_pages[$urandom_range(0, 7)];
    endcase
  endfunction

  function automatic logic [2:0] pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return pbpr_pkg::KIND_PIN;
    if (r < 70) return pbpr_pkg::KIND_UNPIN;
    if (r < 85) return pbpr_pkg::KIND_DIRTY;
    if (r < 92) return pbpr_pkg::KIND_FORCE;
    if (r < 98) return pbpr_pkg::KIND_FLUSH;
    return 3'($urandom_range(5, 7));
  endfunction

  task automatic random_phase(input logic lru, input logic [4:0] frames, input int count);
    write_cfg(pbpr_pkg::CFG_STRATEGY, {4'd0, lru});
    write_cfg(pbpr_pkg::CFG_FRAMES_IN_USE, frames);
    for (int i = 0; i < 8; i++) hot_pages[i] = 20'($urandom());
    for (int i = 0; i < count; i++) send_request(pick_kind(), pick_page());
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: fill, hit, dirty, force, flush, all pinned, unknown pages
    send_request(pbpr_pkg::KIND_DIRTY, 20'h00000);
    send_request(pbpr_pkg::KIND_PIN, 20'h00000);
    send_request(pbpr_pkg::KIND_PIN, 20'hFFFFF);
    send_request(pbpr_pkg::KIND_PIN, 20'h00000);
    send_request(pbpr_pkg::KIND_DIRTY, 20'hFFFFF);
    send_request(pbpr_pkg::KIND_FORCE, 20'hFFFFF);
    send_request(pbpr_pkg::KIND_FORCE, 20'hFFFFF);
    send_request(pbpr_pkg::KIND_DIRTY, 20'h00000);
    send_request(pbpr_pkg::KIND_UNPIN, 20'h00000);
    send_request(pbpr_pkg::KIND_UNPIN, 20'h00000);
    send_request(pbpr_pkg::KIND_UNPIN, 20'h00000);
    send_request(pbpr_pkg::KIND_UNPIN, 20'h12345);
    send_request(pbpr_pkg::KIND_FORCE, 20'h55555);
    send_request(pbpr_pkg::KIND_FLUSH, 20'hAAAAA);
    send_request(pbpr_pkg::KIND_FLUSH, 20'h00000);
    send_request(3'd5, 20'h0);
    send_request(3'd7, 20'hFFFFF);
    wait_idle();
    write_cfg(pbpr_pkg::CFG_FRAMES_IN_USE, 5'd1);
    send_request(pbpr_pkg::KIND_PIN, 20'h00001);
    send_request(pbpr_pkg::KIND_PIN, 20'h00002);
    send_request(pbpr_pkg::KIND_UNPIN, 20'h00001);
    send_request(pbpr_pkg::KIND_PIN, 20'h00002);
    wait_idle();
    write_cfg(pbpr_pkg::CFG_FRAMES_IN_USE, 5'd0);
    send_request(pbpr_pkg::KIND_PIN, 20'h00003);
    wait_idle();
    // random phases across policy and pool size, extremes included
    random_phase(1'b0, 5'd16, 50);
    random_phase(1'b1, 5'd3, 40);
    random_phase(1'b1, 5'd16, 50);
    random_phase(1'b0, 5'd31, 30);
    random_phase(1'b1, 5'd1, 30);
    $display("sent %0d requests, checked %0d results over FIFO/LRU and 0..31 frames",
             requests_sent, results_seen);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire
